### hw/rtl/aprp_pkg.sv
// Package: shared constants, types and helpers for the aging page replacement unit.
`timescale 1ns / 1ps
package aprp_pkg;

  localparam int PAGES   = 64;
  localparam int FRAMES  = 8;
  localparam int PAGE_W  = (PAGES > 1) ? $clog2(PAGES) : 1;
  localparam int FRAME_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int FCNT_W  = $clog2(FRAMES + 1);
  localparam int AGE_W   = 9;
  localparam int IN_PAGE_W = 6;
  localparam int CFG_W   = 4;
  localparam int CNT_W   = 32;
  localparam logic [CFG_W-1:0] FRAMES_RESET = CFG_W'(8);
  localparam logic [AGE_W:0]   AGE_LIMIT    = (AGE_W + 1)'(1 << AGE_W);

  typedef logic [PAGE_W-1:0]  page_t;
  typedef logic [FRAME_W-1:0] frame_t;
  typedef logic [AGE_W-1:0]   age_t;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_LOOK = 4'b0010,
    S_SCAN = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  // Fold an incoming page number into range: a small constant table.
  function automatic page_t page_fold(input logic [IN_PAGE_W-1:0] x);
    page_t r;
    r = '0;
    for (int i = 0; i < (1 << IN_PAGE_W); i++) begin
      if (x == IN_PAGE_W'(i)) r = PAGE_W'(i % PAGES);
    end
    return r;
  endfunction

endpackage

### hw/rtl/aprp_in_if.sv
// Interface: reference word channel (page, end_of_string).
`timescale 1ns / 1ps
interface aprp_in_if;
  logic       valid;
  logic       ready;
  logic [5:0] page;
  logic       end_of_string;

  modport source (output valid, output page, output end_of_string, input ready);
  modport sink   (input valid, input page, input end_of_string, output ready);
endinterface

### hw/rtl/aprp_out_if.sv
// Interface: result word channel.
`timescale 1ns / 1ps
interface aprp_out_if;
  logic        valid;
  logic        ready;
  logic        fault;
  logic [2:0]  frame;
  logic        evicted_valid;
  logic [5:0]  evicted_page;
  logic [31:0] fault_total;
  logic        run_done;

  modport source (output valid, output fault, output frame, output evicted_valid,
                  output evicted_page, output fault_total, output run_done,
                  input ready);
  modport sink   (input valid, input fault, input frame, input evicted_valid,
                  input evicted_page, input fault_total, input run_done,
                  output ready);
endinterface

### hw/rtl/aprp_cfg_if.sv
// Interface: configuration write channel for frames_in_use.
`timescale 1ns / 1ps
interface aprp_cfg_if;
  logic       valid;
  logic       ready;
  logic [3:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### hw/rtl/aprp_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module aprp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                        clk,
  input  logic                                        we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                            wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                            rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### hw/rtl/aprp_age_hist.sv
// Age history: last AGE_W references, giving any page's aging counter on demand.
`timescale 1ns / 1ps
module aprp_age_hist (
  input  logic           clk,
  input  logic           rst,
  input  logic           shift_en,
  input  aprp_pkg::page_t shift_page,
  input  aprp_pkg::page_t probe_page,
  output aprp_pkg::age_t  probe_age
);
  import aprp_pkg::*;

  // slot 0 is the most recent reference; it maps to the top age bit
  page_t       hist_page [AGE_W];
  logic [AGE_W-1:0] hist_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      hist_v <= '0;
    end else if (shift_en) begin
      hist_v <= {hist_v[AGE_W-2:0], 1'b1};
    end
  end

  always_ff @(posedge clk) begin
    if (shift_en) begin
      hist_page[0] <= shift_page;
      for (int k = 1; k < AGE_W; k++) begin
        hist_page[k] <= hist_page[k-1];
      end
    end
  end

  always_comb begin
    for (int k = 0; k < AGE_W; k++) begin
      probe_age[AGE_W-1-k] = hist_v[k] && (hist_page[k] == probe_page);
    end
  end
endmodule

### hw/rtl/aging_page_replacement_unit.sv
// Top level: aging page replacement unit (LRU approximation with 9-bit ages).
// Flow: a hit or a fault into an empty frame passes S_LOOK then S_DONE before its result word
//   is registered; a fault with all active frames full first runs the victim scan in S_SCAN,
//   which reads one frame_page entry per cycle from its RAM. A new reference is taken only in
//   S_IDLE, after the last result word has been committed to the output register.
// Reset (rst, synchronous): clears frame and page-map valid bits, the age history and the
//   fault count, and sets frames_in_use to 8. No clearing pass is needed.
`timescale 1ns / 1ps
module aging_page_replacement_unit (
  input logic        clk,
  input logic        rst,
  aprp_cfg_if.sink   cfg,
  aprp_in_if.sink    req,
  aprp_out_if.source rsp
);
  import aprp_pkg::*;

  state_t state, state_next;

  logic [CFG_W-1:0]  frames_in_use;
  logic [FCNT_W-1:0] n_act;

  // per-reference registers
  page_t  cur_page;
  logic   cur_eos;
  logic   cur_fault;
  frame_t vic;         // chosen frame (or hit frame)
  logic   vic_evict;   // chosen frame held a resident page
  page_t  vic_page;    // that page
  logic [AGE_W:0] best_age;

  // scan pipeline: issue index and compare stage
  logic [FCNT_W-1:0] issue_j;
  logic              cmp_v;
  frame_t            cmp_idx;

  logic [FRAMES-1:0] frame_valid;
  logic [PAGES-1:0]  map_valid;
  logic [CNT_W-1:0]  fault_count;

  // RAM ports
  frame_t map_rdata;
  page_t  fp_rdata;
  frame_t fp_raddr;
  logic   commit;
  age_t   probe_age;

  // first empty frame among the active ones
  logic   empty_found;
  frame_t empty_idx;

  logic [CNT_W-1:0] cnt_inc;
  page_t            in_page;

  assign in_page = page_fold(req.page);
  assign req.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;

  // commit the word once the output register is free
  assign commit = (state == S_DONE) && (!rsp.valid || rsp.ready);

  // active frame count: 0 acts as 1, anything above FRAMES acts as FRAMES
  always_comb begin
    if (frames_in_use == '0) begin
      n_act = FCNT_W'(1);
    end else if (32'(frames_in_use) > 32'(FRAMES)) begin
      n_act = FCNT_W'(FRAMES);
    end else begin
      n_act = FCNT_W'(frames_in_use);
    end
  end

  always_comb begin
    empty_found = 1'b0;
    empty_idx   = '0;
    for (int j = FRAMES - 1; j >= 0; j--) begin
      if ((32'(j) < 32'(n_act)) && !frame_valid[j]) begin
        empty_found = 1'b1;
        empty_idx   = FRAME_W'(j);
      end
    end
  end

  assign fp_raddr = issue_j[FRAME_W-1:0];
  assign cnt_inc  = (cur_fault && (fault_count != '1)) ? fault_count + 1'b1 : fault_count;

  // page -> frame index map; valid bits live in flops
  aprp_ram #(.WIDTH(FRAME_W), .DEPTH(PAGES)) u_map_ram (
    .clk   (clk),
    .we    (commit && cur_fault),
    .waddr (cur_page),
    .wdata (vic),
    .raddr (in_page),
    .rdata (map_rdata)
  );

  // frame -> resident page
  aprp_ram #(.WIDTH(PAGE_W), .DEPTH(FRAMES)) u_frame_ram (
    .clk   (clk),
    .we    (commit && cur_fault),
    .waddr (vic),
    .wdata (cur_page),
    .raddr (fp_raddr),
    .rdata (fp_rdata)
  );

  // ages come from the last nine references
  aprp_age_hist u_age (
    .clk        (clk),
    .rst        (rst),
    .shift_en   (commit),
    .shift_page (cur_page),
    .probe_page (fp_rdata),
    .probe_age  (probe_age)
  );

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req.valid) state_next = S_LOOK;
      end
      S_LOOK: begin
        if (map_valid[cur_page] || empty_found) begin
          state_next = S_DONE;
        end else begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (!cmp_v && (issue_j >= n_act)) state_next = S_DONE;
      end
      S_DONE: begin
        if (commit) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      frames_in_use <= FRAMES_RESET;
      frame_valid   <= '0;
      map_valid     <= '0;
      fault_count   <= '0;
      cmp_v         <= 1'b0;
      rsp.valid     <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg.valid) frames_in_use <= cfg.data;

      if (state == S_SCAN) begin
        cmp_v <= (issue_j < n_act);
      end else begin
        cmp_v <= 1'b0;
      end

      if (commit) begin
        rsp.valid <= 1'b1;
        if (cur_fault) begin
          // evicted page leaves first; it never equals the incoming page
          if (vic_evict) map_valid[vic_page] <= 1'b0;
          map_valid[cur_page] <= 1'b1;
          frame_valid[vic]    <= 1'b1;
        end
        fault_count <= cur_eos ? '0 : cnt_inc;
      end else if (rsp.valid && rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (state == S_IDLE && req.valid) begin
      cur_page <= in_page;
      cur_eos  <= req.end_of_string;
    end

    if (state == S_LOOK) begin
      issue_j  <= '0;
      best_age <= AGE_LIMIT;
      vic_page <= '0;
      if (map_valid[cur_page]) begin
        cur_fault <= 1'b0;
        vic       <= map_rdata;
        vic_evict <= 1'b0;
      end else if (empty_found) begin
        cur_fault <= 1'b1;
        vic       <= empty_idx;
        vic_evict <= 1'b0;
      end else begin
        cur_fault <= 1'b1;
        vic       <= '0;
        vic_evict <= 1'b1;
      end
    end

    if (state == S_SCAN) begin
      if (issue_j < n_act) begin
        issue_j <= issue_j + 1'b1;
      end
      cmp_idx <= issue_j[FRAME_W-1:0];
      // strict less-than keeps the lowest index on ties
      if (cmp_v && ({1'b0, probe_age} < best_age)) begin
        best_age <= {1'b0, probe_age};
        vic      <= cmp_idx;
        vic_page <= fp_rdata;
      end
    end

    if (commit) begin
      rsp.fault         <= cur_fault;
      rsp.frame         <= 3'(vic);
      rsp.evicted_valid <= vic_evict;
      rsp.evicted_page  <= vic_evict ? 6'(vic_page) : 6'd0;
      rsp.fault_total   <= cnt_inc;
      rsp.run_done      <= cur_eos;
    end
  end
endmodule

### hw/rtl/aprp_checker.sv
// Checker: port-level assertions for the aging page replacement unit, with bind.
`timescale 1ns / 1ps
module aprp_checker (
  input logic        clk,
  input logic        rst,
  input logic        req_valid,
  input logic        req_ready,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic        rsp_fault,
  input logic        rsp_evicted_valid,
  input logic [5:0]  rsp_evicted_page,
  input logic [31:0] rsp_fault_total
);
  // a pending result word is held until taken
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("result word dropped while stalled");

  // hits never evict
  a_hit_clean: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_fault |-> !rsp_evicted_valid && (rsp_evicted_page == 6'd0))
    else $error("hit reported an eviction");

  // a faulting word has counted at least itself
  a_fault_count: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_fault |-> (rsp_fault_total != 32'd0))
    else $error("fault with zero fault total");

  // no reference is taken in the cycle right after another
  a_no_b2b: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("reference accepted in back-to-back cycles");
endmodule

bind aging_page_replacement_unit aprp_checker u_aprp_checker (
  .clk               (clk),
  .rst               (rst),
  .req_valid         (req.valid),
  .req_ready         (req.ready),
  .rsp_valid         (rsp.valid),
  .rsp_ready         (rsp.ready),
  .rsp_fault         (rsp.fault),
  .rsp_evicted_valid (rsp.evicted_valid),
  .rsp_evicted_page  (rsp.evicted_page),
  .rsp_fault_total   (rsp.fault_total)
);
